// File: hw/rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared constants and types for the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 32;
  localparam int QUEUE_DEPTH    = 2;

  // Request codes on req_type
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Command flags handed from the front end to the stepping engine
  typedef struct packed {
    logic is_start;
    logic swapped;
    logic down;
  } lps_flags_t;

endpackage

// File: hw/rtl/lps_front.sv
// ----------------------------------------------------------------------------
// lps_front
// Input stage: takes requests, classifies steep lines, orders the endpoints
// along the major axis and forms span and error increment for the engine.
// ----------------------------------------------------------------------------
module lps_front #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [COORD_BITS-1:0]         x_start,
  input  logic [COORD_BITS-1:0]         y_start,
  input  logic [COORD_BITS-1:0]         x_end,
  input  logic [COORD_BITS-1:0]         y_end,
  input  logic [lps_pkg::COLOR_BITS-1:0] pen_color,
  output logic                          push,
  input  logic                          queue_full,
  output lps_pkg::lps_flags_t           push_flags,
  output logic [5*COORD_BITS+lps_pkg::COLOR_BITS:0] push_data
);

  localparam int W = COORD_BITS;

  logic                          s1_valid;
  logic                          s1_start;
  logic                          s1_steep;
  logic [W-1:0]                  s1_ax, s1_ay, s1_bx, s1_by;
  logic [lps_pkg::COLOR_BITS-1:0] s1_color;

  // steepness from the raw endpoints; both differences in parallel
  logic [W:0]   dx_fw, dy_fw;
  logic [W-1:0] dx_bw, dy_bw, adx, ady;
  logic         steep;

  assign dx_fw = {1'b0, x_end} - {1'b0, x_start};
  assign dx_bw = x_start - x_end;
  assign dy_fw = {1'b0, y_end} - {1'b0, y_start};
  assign dy_bw = y_start - y_end;
  assign adx   = dx_fw[W] ? dx_bw : dx_fw[W-1:0];
  assign ady   = dy_fw[W] ? dy_bw : dy_fw[W-1:0];
  assign steep = adx < ady;

  logic accept;
  assign in_stall = s1_valid && queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (!queue_full) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start <= (req_type == lps_pkg::REQ_START);
      s1_steep <= steep;
      s1_ax    <= x_start;
      s1_ay    <= y_start;
      s1_bx    <= x_end;
      s1_by    <= y_end;
      s1_color <= pen_color;
    end
  end

  // axis swap and left-to-right ordering
  logic [W-1:0] mj0, mj1, mn0, mn1;
  logic [W:0]   dmaj;
  logic         flip;
  logic [W-1:0] maj_pos, maj_stop, mn_pos, mn_end, span, adm;
  logic [W:0]   dmin;
  logic         down;

  always_comb begin
    mj0      = s1_steep ? s1_ay : s1_ax;
    mn0      = s1_steep ? s1_ax : s1_ay;
    mj1      = s1_steep ? s1_by : s1_bx;
    mn1      = s1_steep ? s1_bx : s1_by;
    dmaj     = {1'b0, mj1} - {1'b0, mj0};
    flip     = dmaj[W];
    maj_pos  = flip ? mj1 : mj0;
    maj_stop = flip ? mj0 : mj1;
    mn_pos   = flip ? mn1 : mn0;
    mn_end   = flip ? mn0 : mn1;
    span     = flip ? (mj0 - mj1) : dmaj[W-1:0];
    dmin     = {1'b0, mn_end} - {1'b0, mn_pos};
    down     = dmin[W];
    adm      = down ? (mn_pos - mn_end) : dmin[W-1:0];
  end

  assign push_flags.is_start = s1_start;
  assign push_flags.swapped  = s1_steep;
  assign push_flags.down     = down;
  assign push_data = {maj_pos, maj_stop, mn_pos, span, adm, 1'b0, s1_color};

endmodule

// File: hw/rtl/lps_queue.sv
// ----------------------------------------------------------------------------
// lps_queue
// Short register FIFO between the front end and the stepping engine.
// ----------------------------------------------------------------------------
module lps_queue #(
  parameter int DATA_BITS = 8,
  parameter int DEPTH     = lps_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] wr_data,
  output logic                 full,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] rd_data,
  output logic                 empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 do_push, do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/lps_back.sv
// ----------------------------------------------------------------------------
// lps_back
// Stepping engine: holds the line state, runs one Bresenham step per advance
// command while a line is active and drives the registered pixel output.
// ----------------------------------------------------------------------------
module lps_back #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_empty,
  input  lps_pkg::lps_flags_t                       q_flags,
  input  logic [5*COORD_BITS+lps_pkg::COLOR_BITS:0] q_data,
  output logic                                      pop,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [COORD_BITS-1:0]                     pixel_x,
  output logic [COORD_BITS-1:0]                     pixel_y,
  output logic [lps_pkg::COLOR_BITS-1:0]            pixel_color,
  output logic                                      last_pixel
);

  localparam int W  = COORD_BITS;
  localparam int CB = lps_pkg::COLOR_BITS;
  localparam int EW = W + 3;

  // command fields
  logic [W-1:0]  c_major, c_stop, c_minor, c_span;
  logic [W:0]    c_incr;
  logic [CB-1:0] c_color;

  assign c_color = q_data[CB-1:0];
  assign c_incr  = q_data[CB+W:CB];
  assign c_span  = q_data[CB+2*W:CB+W+1];
  assign c_minor = q_data[CB+3*W:CB+2*W+1];
  assign c_stop  = q_data[CB+4*W:CB+3*W+1];
  assign c_major = q_data[CB+5*W:CB+4*W+1];

  // line state
  logic                 line_active, line_active_next;
  logic                 axes_swapped, axes_swapped_next;
  logic                 minor_goes_down, minor_goes_down_next;
  logic [W-1:0]         major_pos, major_pos_next;
  logic [W-1:0]         major_stop, major_stop_next;
  logic [W-1:0]         minor_pos, minor_pos_next;
  logic [W-1:0]         major_span, major_span_next;
  logic [W:0]           err_incr, err_incr_next;
  logic signed [EW-1:0] err_acc, err_acc_next;
  logic [CB-1:0]        held_color, held_color_next;

  // output staging
  logic          out_load;
  logic [W-1:0]  px_next, py_next;
  logic          last_next;

  // step datapath
  logic signed [EW-1:0] err_sum, err_sub;
  logic                 take;
  logic [W-1:0]         major_inc, minor_step, minor_adv;

  assign err_sum    = err_acc + $signed({2'b00, err_incr});
  assign err_sub    = err_acc + $signed({2'b00, err_incr}) - $signed({2'b00, major_span, 1'b0});
  assign take       = err_sum > $signed({3'b000, major_span});
  assign major_inc  = major_pos + 1'b1;
  assign minor_step = minor_goes_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
  assign minor_adv  = take ? minor_step : minor_pos;

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    line_active_next     = line_active;
    axes_swapped_next    = axes_swapped;
    minor_goes_down_next = minor_goes_down;
    major_pos_next       = major_pos;
    major_stop_next      = major_stop;
    minor_pos_next       = minor_pos;
    major_span_next      = major_span;
    err_incr_next        = err_incr;
    err_acc_next         = err_acc;
    held_color_next      = held_color;
    out_load             = 1'b0;
    last_next            = 1'b0;
    px_next              = major_inc;
    py_next              = minor_adv;
    if (pop) begin
      if (q_flags.is_start) begin
        axes_swapped_next    = q_flags.swapped;
        minor_goes_down_next = q_flags.down;
        major_pos_next       = c_major;
        major_stop_next      = c_stop;
        minor_pos_next       = c_minor;
        major_span_next      = c_span;
        err_incr_next        = c_incr;
        err_acc_next         = '0;
        held_color_next      = c_color;
        last_next            = (c_major == c_stop);
        line_active_next     = !last_next;
        out_load             = 1'b1;
        px_next              = q_flags.swapped ? c_minor : c_major;
        py_next              = q_flags.swapped ? c_major : c_minor;
      end else if (line_active) begin
        major_pos_next   = major_inc;
        minor_pos_next   = minor_adv;
        err_acc_next     = take ? err_sub : err_sum;
        last_next        = (major_inc == major_stop);
        line_active_next = !last_next;
        out_load         = 1'b1;
        px_next          = axes_swapped ? minor_adv : major_inc;
        py_next          = axes_swapped ? major_inc : minor_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      line_active <= line_active_next;
      if (pop) begin
        out_valid <= out_load;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    axes_swapped    <= axes_swapped_next;
    minor_goes_down <= minor_goes_down_next;
    major_pos       <= major_pos_next;
    major_stop      <= major_stop_next;
    minor_pos       <= minor_pos_next;
    major_span      <= major_span_next;
    err_incr        <= err_incr_next;
    err_acc         <= err_acc_next;
    held_color      <= held_color_next;
    if (out_load) begin
      pixel_x     <= px_next;
      pixel_y     <= py_next;
      pixel_color <= held_color_next;
      last_pixel  <= last_next;
    end
  end

endmodule

// File: hw/rtl/line_pixel_stepper_unit.sv
// Path: a request is registered in the input stage, written to the queue, then
// stepped by the engine into the output register, from which it can transfer.
// Throughput: one request per cycle while in_stall is low; each step is one add,
// compare and subtract in the engine, so a pixel leaves every cycle the output is free.
// Reset (rst, synchronous): empties the input stage, the queue and the output
// register and leaves the engine idle.
// ----------------------------------------------------------------------------
// line_pixel_stepper_unit
// Bresenham line engine: front end decodes start/advance requests, a short
// queue decouples it from the stepping engine that emits pixels.
// ----------------------------------------------------------------------------
module line_pixel_stepper_unit #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [COORD_BITS-1:0]          x_start,
  input  logic [COORD_BITS-1:0]          y_start,
  input  logic [COORD_BITS-1:0]          x_end,
  input  logic [COORD_BITS-1:0]          y_end,
  input  logic [lps_pkg::COLOR_BITS-1:0] pen_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COORD_BITS-1:0]          pixel_x,
  output logic [COORD_BITS-1:0]          pixel_y,
  output logic [lps_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                           last_pixel
);

  localparam int DATA_BITS = 5 * COORD_BITS + lps_pkg::COLOR_BITS + 1;
  localparam int FLAG_BITS = $bits(lps_pkg::lps_flags_t);
  localparam int WORD_BITS = DATA_BITS + FLAG_BITS;

  logic                  push, queue_full, queue_empty, pop;
  lps_pkg::lps_flags_t   push_flags, q_flags;
  logic [DATA_BITS-1:0]  push_data, q_data;
  logic [WORD_BITS-1:0]  q_word;

  lps_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .pen_color (pen_color),
    .push      (push),
    .queue_full(queue_full),
    .push_flags(push_flags),
    .push_data (push_data)
  );

  lps_queue #(
    .DATA_BITS(WORD_BITS),
    .DEPTH    (lps_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data({push_flags, push_data}),
    .full   (queue_full),
    .pop    (pop),
    .rd_data(q_word),
    .empty  (queue_empty)
  );

  assign q_flags = q_word[WORD_BITS-1 -: FLAG_BITS];
  assign q_data  = q_word[DATA_BITS-1:0];

  lps_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (queue_empty),
    .q_flags    (q_flags),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .last_pixel (last_pixel)
  );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Bresenham line stepper. Start and advance
// requests go in over a valid/stall channel. A behavioral line walker predicts
// every pixel, and a monitor checks each pixel transfer in order against it.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = lps_pkg::COORD_BITS_DEF;
  localparam int CLR       = lps_pkg::COLOR_BITS;
  localparam int MAX_COORD = (1 << CW) - 1;
  localparam int RAND_REQS = 450;
  localparam int LIMIT     = 200000;

  typedef struct packed {
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic [CLR-1:0] color;
    logic           last;
  } pixel_t;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  logic           req_type;
  logic [CW-1:0]  x_start;
  logic [CW-1:0]  y_start;
  logic [CW-1:0]  x_end;
  logic [CW-1:0]  y_end;
  logic [CLR-1:0] pen_color;
  logic           out_valid;
  logic           out_stall;
  logic [CW-1:0]  pixel_x;
  logic [CW-1:0]  pixel_y;
  logic [CLR-1:0] pixel_color;
  logic           last_pixel;

  line_pixel_stepper_unit #(.COORD_BITS(CW)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .pen_color   (pen_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

  // Line walker state
  logic           walk_active;
  logic           walk_steep;
  logic [CW-1:0]  walk_major;
  logic [CW-1:0]  walk_stop;
  logic [CW-1:0]  walk_minor;
  logic           walk_down;
  int             walk_err;
  int             walk_incr;
  int             walk_span;
  logic [CLR-1:0] walk_color;

  pixel_t pixel_q[$];
  bit     calm;
  int     errors;
  int     pixels_predicted;
  int     pixels_checked;
  int     lines_started;
  int     steep_lines;
  int     restarts;
  int     cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("%0t: timeout, %0d pixels still expected", $time, pixel_q.size());
        $display("FAIL line_pixel_stepper_unit");
        $finish;
      end
    end
  end

  // Receiver back-pressure
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  // Walk one request through the line walker; queue its pixel if it makes one
  task automatic walk_line(input logic kind, input logic [CW-1:0] xs, input logic [CW-1:0] ys,
                           input logic [CW-1:0] xe, input logic [CW-1:0] ye,
                           input logic [CLR-1:0] color);
    int     ax, ay, bx, by, t, adx, ady;
    pixel_t p;
    if (kind == lps_pkg::REQ_START) begin
      ax = xs; ay = ys; bx = xe; by = ye;
      adx = ax > bx ? ax - bx : bx - ax;
      ady = ay > by ? ay - by : by - ay;
      if (walk_active) restarts++;
      lines_started++;
      walk_steep = adx < ady;
      if (walk_steep) begin
        steep_lines++;
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      walk_major = ax[CW-1:0];
      walk_stop  = bx[CW-1:0];
      walk_minor = ay[CW-1:0];
      walk_down  = by < ay;
      walk_span  = bx - ax;
      walk_incr  = 2 * (by > ay ? by - ay : ay - by);
      walk_err   = 0;
      walk_color = color;
    end else if (!walk_active) begin
      return;
    end else begin
      walk_err += walk_incr;
      if (walk_err > walk_span) begin
        walk_minor = walk_down ? walk_minor - 1'b1 : walk_minor + 1'b1;
        walk_err -= 2 * walk_span;
      end
      walk_major = walk_major + 1'b1;
    end
    p.x     = walk_steep ? walk_minor : walk_major;
    p.y     = walk_steep ? walk_major : walk_minor;
    p.color = walk_color;
    p.last  = (walk_major == walk_stop);
    walk_active = !p.last;
    pixel_q.push_back(p);
    pixels_predicted++;
  endtask

  // One request transfer; valid stays up across back-to-back requests
  task automatic send_req(input logic kind, input logic [CW-1:0] xs, input logic [CW-1:0] ys,
                          input logic [CW-1:0] xe, input logic [CW-1:0] ye,
                          input logic [CLR-1:0] color);
    in_valid  <= 1'b1;
    req_type  <= kind;
    x_start   <= xs;
    y_start   <= ys;
    x_end     <= xe;
    y_end     <= ye;
    pen_color <= color;
    do @(posedge clk); while (in_stall);
    walk_line(kind, xs, ys, xe, ye, color);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic start_line(input int xs, input int ys, input int xe, input int ye,
                            input logic [CLR-1:0] color);
    send_req(lps_pkg::REQ_START, xs[CW-1:0], ys[CW-1:0], xe[CW-1:0], ye[CW-1:0], color);
  endtask

  // Coordinates and color of an advance are ignored, so they carry noise
  task automatic advance_pixel();
    send_req(lps_pkg::REQ_ADVANCE, CW'($urandom), CW'($urandom), CW'($urandom),
             CW'($urandom), $urandom);
  endtask

  task automatic finish_line();
    while (walk_active) advance_pixel();
  endtask

  function automatic int clamp_coord(input int v);
    return v < 0 ? 0 : (v > MAX_COORD ? MAX_COORD : v);
  endfunction

  // Pixel monitor
  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{pixel_x, pixel_y, pixel_color, last_pixel};
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%0b",
                 $time, got.x, got.y, got.color, got.last);
      end else begin
        want = pixel_q.pop_front();
        pixels_checked++;
        if (got.x != want.x) begin
          errors++;
          $display("%0t: pixel_x expected %0d got %0d", $time, want.x, got.x);
        end
        if (got.y != want.y) begin
          errors++;
          $display("%0t: pixel_y expected %0d got %0d", $time, want.y, got.y);
        end
        if (got.color != want.color) begin
          errors++;
          $display("%0t: pixel_color expected %h got %h", $time, want.color, got.color);
        end
        if (got.last != want.last) begin
          errors++;
          $display("%0t: last_pixel expected %0b got %0b", $time, want.last, got.last);
        end
      end
    end
  end

  task automatic test_idle_advance();
    advance_pixel();
    advance_pixel();
  endtask

  task automatic test_single_pixel();
    start_line(0, 0, 0, 0, 32'h0000_0000);
    start_line(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 32'hFFFF_FFFF);
    advance_pixel();
  endtask

  task automatic test_directions();
    // right end of the x range, walked right to left
    start_line(MAX_COORD, 0, MAX_COORD - 2, 0, 32'hA5A5_5A5A);
    finish_line();
    start_line(0, 0, 3, 1, 32'h1234_5678);
    finish_line();
    // steep, minor axis stepping up
    start_line(10, 20, 9, 17, 32'h5A5A_A5A5);
    finish_line();
    // equal deltas keep x as the major axis
    start_line(MAX_COORD, 0, MAX_COORD - 2, 2, 32'hDEAD_BEEF);
    finish_line();
    start_line(5, 5, 2, 6, 32'h0F0F_F0F0);
    finish_line();
    advance_pixel();
  endtask

  task automatic test_restart();
    start_line(0, 0, MAX_COORD, MAX_COORD, 32'hFFFF_0000);
    advance_pixel();
    advance_pixel();
    start_line(7, 7, 7, 8, 32'h0000_FFFF);
    finish_line();
  endtask

  task automatic test_random_lines();
    int base, done, sel, xs, ys, xe, ye;
    base = pixels_predicted;
    done = 0;
    while (done < RAND_REQS) begin
      calm = (done >= 150 && done < 260);
      sel  = $urandom_range(99);
      if (sel < 70) begin
        // short line anywhere on the grid, walked to its end
        xs = $urandom_range(MAX_COORD);
        ys = $urandom_range(MAX_COORD);
        xe = clamp_coord(xs + $urandom_range(32) - 16);
        ye = clamp_coord(ys + $urandom_range(32) - 16);
        start_line(xs, ys, xe, ye, $urandom);
        finish_line();
        if ($urandom_range(9) == 0) advance_pixel();
      end else if (sel < 85) begin
        // long line, cut short by a later start
        start_line($urandom_range(MAX_COORD), $urandom_range(MAX_COORD),
                   $urandom_range(MAX_COORD), $urandom_range(MAX_COORD), $urandom);
        repeat ($urandom_range(3, 30)) advance_pixel();
      end else begin
        repeat ($urandom_range(1, 3)) advance_pixel();
      end
      done = pixels_predicted - base;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= lps_pkg::REQ_START;
    x_start   <= '0;
    y_start   <= '0;
    x_end     <= '0;
    y_end     <= '0;
    pen_color <= '0;
    calm = 1'b0;
    errors = 0;
    pixels_predicted = 0;
    pixels_checked = 0;
    lines_started = 0;
    steep_lines = 0;
    restarts = 0;
    walk_active = 1'b0;
    walk_steep = 1'b0;
    walk_major = '0;
    walk_stop = '0;
    walk_minor = '0;
    walk_down = 1'b0;
    walk_err = 0;
    walk_incr = 0;
    walk_span = 0;
    walk_color = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_advance();
    test_single_pixel();
    test_directions();
    test_restart();
    test_random_lines();

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Ran %0d lines (%0d steep, %0d dropped by a new start); %0d pixels checked.",
             lines_started, steep_lines, restarts, pixels_checked);
    if (errors == 0) begin
      $display("PASS line_pixel_stepper_unit");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL line_pixel_stepper_unit");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lps_pkg.sv
hw/rtl/lps_front.sv
hw/rtl/lps_queue.sv
hw/rtl/lps_back.sv
hw/rtl/line_pixel_stepper_unit.sv
sim/tb.sv
